FILE: rtl/stfi_pkg.sv
// ----------------------------------------------------------------------------
// stfi_pkg
// Shared constants for the sorted key table: default sizes and result codes.
// ----------------------------------------------------------------------------
package stfi_pkg;

  localparam int unsigned CAPACITY_DEFAULT  = 256;
  localparam int unsigned KEY_WIDTH_DEFAULT = 32;

  localparam int unsigned SEARCH_KEY_W  = 32;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned POSITION_W    = 8;
  localparam int unsigned ENTRY_COUNT_W = 9;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_FOUND    = 2'd0;
  localparam status_t ST_INSERTED = 2'd1;
  localparam status_t ST_FULL     = 2'd2;

endpackage

FILE: rtl/sorted_table_find_or_insert.sv
// ----------------------------------------------------------------------------
// sorted_table_find_or_insert
// Keeps keys in ascending unsigned order. A request finds its key by binary
// search, inserts it at its sorted place shifting higher keys up, or reports
// a full table.
//   channel   signals                                  handshake
//   request   search_key                               start & !busy
//   result    status, position, entry_count            done (one cycle)
//
// Each binary search probe has a read state and a compare state; a request
// makes about log2(count)+1 probes, then resolves, and for an insert moves
// one entry per shift step and then writes the key, all through the single
// read and write port.
// The result strobe follows the last cycle; busy is low in that cycle.
// Reset empties the table at once; key storage is never cleared.
// ----------------------------------------------------------------------------
module sorted_table_find_or_insert
  import stfi_pkg::*;
#(
  parameter int unsigned CAPACITY  = CAPACITY_DEFAULT,
  parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [SEARCH_KEY_W-1:0]  search_key,
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic [POSITION_W-1:0]    position,
  output logic [ENTRY_COUNT_W-1:0] entry_count
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE_RD,
    S_PROBE_CMP,
    S_RESOLVE,
    S_SHIFT,
    S_WRITE_KEY
  } state_t;

  state_t               state;
  logic [KEY_WIDTH-1:0] key;
  logic [CW-1:0]        count;
  logic [CW-1:0]        lo;
  logic [CW-1:0]        hi;
  logic [CW-1:0]        src;
  logic                 found;

  logic [CW-1:0]        mid;
  logic [CW-1:0]        lo_next;
  logic [CW-1:0]        hi_next;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [KEY_WIDTH-1:0] wdata;
  logic [AW-1:0]        raddr;
  logic [KEY_WIDTH-1:0] rdata;

  stfi_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy = (state != S_IDLE);
  assign mid  = lo + ((hi - lo) >> 1);

  // probe step of the search
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (rdata < key) begin
      lo_next = mid + CW'(1);
    end else begin
      hi_next = mid;
    end
  end

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = lo[AW-1:0];
    wdata = key;
    raddr = mid[AW-1:0];
    case (state)
      S_RESOLVE: begin
        raddr = AW'(count - CW'(1));
      end
      S_SHIFT: begin
        we    = 1'b1;
        waddr = AW'(src + CW'(1));
        wdata = rdata;
        raddr = AW'(src - CW'(1));
      end
      S_WRITE_KEY: begin
        we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            key   <= KEY_WIDTH'(search_key);
            lo    <= '0;
            hi    <= count;
            found <= 1'b0;
            state <= (count == '0) ? S_RESOLVE : S_PROBE_RD;
          end
        end
        S_PROBE_RD: begin
          state <= S_PROBE_CMP;
        end
        S_PROBE_CMP: begin
          if (rdata == key) begin
            found <= 1'b1;
          end
          lo    <= lo_next;
          hi    <= hi_next;
          state <= (lo_next < hi_next) ? S_PROBE_RD : S_RESOLVE;
        end
        S_RESOLVE: begin
          if (found) begin
            done        <= 1'b1;
            status      <= ST_FOUND;
            position    <= POSITION_W'(lo);
            entry_count <= ENTRY_COUNT_W'(count);
            state       <= S_IDLE;
          end else if (count == CW'(CAPACITY)) begin
            done        <= 1'b1;
            status      <= ST_FULL;
            position    <= '0;
            entry_count <= ENTRY_COUNT_W'(count);
            state       <= S_IDLE;
          end else if (lo == count) begin
            state <= S_WRITE_KEY;
          end else begin
            src   <= count - CW'(1);
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (src == lo) begin
            state <= S_WRITE_KEY;
          end else begin
            src <= src - CW'(1);
          end
        end
        S_WRITE_KEY: begin
          count       <= count + CW'(1);
          done        <= 1'b1;
          status      <= ST_INSERTED;
          position    <= POSITION_W'(lo);
          entry_count <= ENTRY_COUNT_W'(count + CW'(1));
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/stfi_ram.sv
// ----------------------------------------------------------------------------
// stfi_ram
// Key storage: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module stfi_ram
  import stfi_pkg::*;
#(
  parameter int unsigned DEPTH = CAPACITY_DEFAULT,
  parameter int unsigned WIDTH = KEY_WIDTH_DEFAULT,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: tb/sv/sorted_table_find_or_insert_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_find_or_insert_tb
// Drives search keys into the sorted key table. Each accepted request is run
// through a behavioral copy of the table that finds or inserts the key, or
// reports it full. Every result strobe is checked field by field against
// the oldest predicted outcome. The run starts with a short directed set of
// edge keys. Random phases with different sender idle rates follow and grow
// the table toward full. The sender drains between phases.
// ----------------------------------------------------------------------------
module sorted_table_find_or_insert_tb;
  import stfi_pkg::*;

  localparam int unsigned TABLE_DEPTH     = CAPACITY_DEFAULT;
  localparam int unsigned HALF_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned PHASE_COUNT     = 6;
  localparam int unsigned PHASE_REQUESTS  = 222;
  localparam int unsigned TAIL_CYCLES     = 2 * 16 + TABLE_DEPTH + 16;
  localparam int unsigned CYCLE_LIMIT     = 2_000_000;
  localparam int unsigned MAX_PRINTED     = 100;

  typedef struct packed {
    logic [SEARCH_KEY_W-1:0]  key;
    status_t                  status;
    logic [POSITION_W-1:0]    position;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } outcome_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [SEARCH_KEY_W-1:0]  search_key = '0;
  logic                     done;
  logic [STATUS_W-1:0]      status;
  logic [POSITION_W-1:0]    position;
  logic [ENTRY_COUNT_W-1:0] entry_count;

  logic [SEARCH_KEY_W-1:0]  shadow_keys [TABLE_DEPTH];
  int unsigned              shadow_count = 0;

  outcome_t                 outcome_q [$];
  logic [SEARCH_KEY_W-1:0]  key_q [$];
  logic [SEARCH_KEY_W-1:0]  issued_keys [$];
  bit                       key_seen [logic [SEARCH_KEY_W-1:0]];

  int unsigned pushed_total = 0;
  int unsigned offered_cnt  = 0;
  int unsigned accepted_cnt = 0;
  int unsigned results_cnt  = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_pct     = 0;

  sorted_table_find_or_insert #(
    .CAPACITY  (TABLE_DEPTH),
    .KEY_WIDTH (KEY_WIDTH_DEFAULT)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .search_key  (search_key),
    .done        (done),
    .status      (status),
    .position    (position),
    .entry_count (entry_count)
  );

  initial begin
    forever #(HALF_PERIOD) clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // lower-bound search, then shift up and store when absent and not full
  function automatic outcome_t table_find_or_insert(input logic [SEARCH_KEY_W-1:0] key);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned idx;
    outcome_t    res;
    lo = 0;
    hi = shadow_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_keys[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    res.key = key;
    if (lo < shadow_count && shadow_keys[lo] == key) begin
      res.status = ST_FOUND;
    end else if (shadow_count >= TABLE_DEPTH) begin
      res.status = ST_FULL;
      lo = 0;
    end else begin
      for (idx = shadow_count; idx > lo; idx--) begin
        shadow_keys[idx] = shadow_keys[idx-1];
      end
      shadow_keys[lo] = key;
      shadow_count++;
      res.status = ST_INSERTED;
    end
    res.position    = lo[POSITION_W-1:0];
    res.entry_count = shadow_count[ENTRY_COUNT_W-1:0];
    return res;
  endfunction

  function automatic void queue_key(input logic [SEARCH_KEY_W-1:0] key);
    key_q.push_back(key);
    pushed_total++;
    if (!key_seen.exists(key)) begin
      key_seen[key] = 1'b1;
      issued_keys.push_back(key);
    end
  endfunction

  // mostly keys near or equal to ones already sent, some fresh ones
  function automatic logic [SEARCH_KEY_W-1:0] pick_key();
    logic [SEARCH_KEY_W-1:0] base;
    int unsigned             sel;
    sel = $urandom_range(99);
    if (issued_keys.size() == 0 || sel < 15) begin
      return $urandom;
    end
    base = issued_keys[$urandom_range(issued_keys.size() - 1)];
    if (sel < 55) begin
      return base;
    end else if (sel < 75) begin
      return base + 1;
    end else if (sel < 85) begin
      return base - 1;
    end else if (sel < 92) begin
      return $urandom_range(15);
    end
    return ~$urandom_range(15);
  endfunction

  task automatic wait_for_results();
    while (results_cnt != pushed_total) @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || accepted_cnt == offered_cnt) begin
      if (key_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        search_key  <= key_q.pop_front();
        start       <= 1'b1;
        offered_cnt <= offered_cnt + 1;
      end else begin
        start      <= 1'b0;
        search_key <= $urandom;
      end
    end
  end

  // result checker and request prediction
  always @(posedge clk) begin
    outcome_t want;
    if (!rst) begin
      if ($isunknown(done)) begin
        report_mismatch("done is unknown");
      end
      if (done) begin
        results_cnt <= results_cnt + 1;
        if (outcome_q.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = outcome_q.pop_front();
          if (status !== want.status) begin
            report_mismatch($sformatf("key %h: status %0d, expected %0d",
                                      want.key, status, want.status));
          end
          if (position !== want.position) begin
            report_mismatch($sformatf("key %h: position %0d, expected %0d",
                                      want.key, position, want.position));
          end
          if (entry_count !== want.entry_count) begin
            report_mismatch($sformatf("key %h: entry_count %0d, expected %0d",
                                      want.key, entry_count, want.entry_count));
          end
        end
      end
      if (start && !busy) begin
        outcome_q.push_back(table_find_or_insert(search_key));
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("sorted_table_find_or_insert_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned idle_levels [PHASE_COUNT];
    idle_levels = '{0, 73, 0, 18, 73, 0};
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, ends of the key range, below first, above last, middle
    queue_key(32'h8000_0000); queue_key(32'h8000_0000); queue_key(32'h0000_0000);
    queue_key(32'hFFFF_FFFF); queue_key(32'h0000_0000); queue_key(32'hFFFF_FFFF);
    queue_key(32'h7FFF_FFFF); queue_key(32'h8000_0001); queue_key(32'h0000_0001);
    queue_key(32'hFFFF_FFFE); queue_key(32'h5555_5555); queue_key(32'hAAAA_AAAA);
    queue_key(32'h7FFF_FFFF); queue_key(32'h8000_0000); queue_key(32'h0000_FFFF);
    queue_key(32'hFFFF_0000); queue_key(32'h0000_0002); queue_key(32'hFFFF_FFFD);
    wait_for_results();

    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
      idle_pct = idle_levels[phase];
      repeat (PHASE_REQUESTS) queue_key(pick_key());
      wait_for_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (outcome_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", outcome_q.size()));
    end
    if (mismatches == 0) begin
      $display("sorted_table_find_or_insert_tb: PASS");
    end else begin
      $display("sorted_table_find_or_insert_tb: FAIL");
    end
    $finish;
  end

endmodule
